/* rtl/emgfd_pkg.sv */
// shared types, constants and helper functions of the emg stream deframer
package emgfd_pkg;

    // frame format codes
    localparam logic [1:0] FMT_RAW    = 2'd0;
    localparam logic [1:0] FMT_HEADED = 2'd1;

    // configuration register indexes
    localparam logic [1:0] REG_FRAME_FORMAT     = 2'd0;
    localparam logic [1:0] REG_CHANNELS_PER_ROW = 2'd1;

    // reset values of the configuration registers
    localparam logic [1:0] FRAME_FORMAT_RST     = FMT_RAW;
    localparam logic [7:0] CHANNELS_PER_ROW_RST = 8'd64;

    // header words as they arrive, first byte highest
    localparam logic [31:0] HDR_HEADED = 32'hFFCC5500;
    localparam logic [31:0] HDR_LEGACY = 32'hFFAA5500;

    // frame header length and body lengths in bytes after the header
    localparam logic [8:0] F1_BODY = 9'd126;
    localparam logic [8:0] F2_SEMG = 9'd54;
    localparam logic [8:0] F2_BODY = 9'd62;
    localparam logic [8:0] HDR_LEN = 9'd4;

    typedef struct packed {
        logic [1:0] frame_format;
        logic [7:0] channels_per_row;
    } t_cfg;

    typedef struct packed {
        logic [8:0]  byte_position;
        logic [23:0] header_bytes;
        logic [15:0] partial_sample;
        logic [7:0]  accel_status_byte;
        logic [6:0]  column_count;
    } t_state;

    typedef struct packed {
        logic [23:0] sample_value;
        logic [6:0]  column_index;
        logic        is_accel;
        logic        row_last;
    } t_result;

    // remainder by 18 of an offset below 126
    function automatic logic [4:0] mod18(input logic [6:0] v);
        logic [6:0] t;
        t = v;
        if (t >= 7'd72) t = t - 7'd72;
        if (t >= 7'd36) t = t - 7'd36;
        if (t >= 7'd18) t = t - 7'd18;
        return t[4:0];
    endfunction

    // remainder by 3 of a value below 24
    function automatic logic [1:0] mod3(input logic [4:0] v);
        logic [4:0] t;
        t = v;
        if (t >= 5'd12) t = t - 5'd12;
        if (t >= 5'd6)  t = t - 5'd6;
        if (t >= 5'd3)  t = t - 5'd3;
        return t[1:0];
    endfunction

endpackage

/* rtl/emgfd_step.sv */
// per-byte decode: next framing state and the optional decoded value
module emgfd_step import emgfd_pkg::*; #(
    parameter int MAX_CHANNELS = 128
) (
    input  t_cfg       i_cfg,
    input  t_state     i_state,
    input  logic [7:0] i_data_byte,
    output t_state     o_state,
    output logic       o_res_valid,
    output t_result    o_res
);

    localparam logic [8:0] MaxN = 9'(MAX_CHANNELS);

    logic [8:0]  n_chan;
    logic [9:0]  pos_p1;
    logic [8:0]  offs;
    logic [4:0]  r18;
    logic [4:0]  r27;
    logic [1:0]  s3;
    logic [8:0]  acc_offs;
    logic [1:0]  acc_sel;
    logic [1:0]  hi;
    logic [31:0] word;
    logic [31:0] want;
    logic        step;
    logic        emit;
    logic        last;
    logic        accel;
    logic [23:0] val;

    // channel count clamped to one .. MAX_CHANNELS
    always_comb begin
        n_chan = {1'b0, i_cfg.channels_per_row};
        if (n_chan == 9'd0) n_chan = 9'd1;
        if (n_chan > MaxN)  n_chan = MaxN;
    end

    // offsets within the frame body
    assign pos_p1   = {1'b0, i_state.byte_position} + 10'd1;
    assign offs     = i_state.byte_position - HDR_LEN;
    assign r18      = mod18(offs[6:0]);
    assign r27      = (offs >= 9'd27) ? 5'(offs - 9'd27) : offs[4:0];
    assign s3       = mod3(r27 - 5'd3);
    assign acc_offs = offs - F2_SEMG;
    assign acc_sel  = acc_offs[1:0];
    assign word     = {i_state.header_bytes, i_data_byte};
    assign want     = (i_cfg.frame_format == FMT_HEADED) ? HDR_HEADED : HDR_LEGACY;

    // accelerometer top bits picked from the status byte
    always_comb begin
        unique case (acc_sel)
            2'd1:    hi = i_state.accel_status_byte[7:6];
            2'd2:    hi = i_state.accel_status_byte[5:4];
            default: hi = i_state.accel_status_byte[3:2];
        endcase
    end

    // format decode and state update
    always_comb begin
        o_state = i_state;
        step    = 1'b0;
        emit    = 1'b0;
        last    = 1'b0;
        accel   = 1'b0;
        val     = '0;
        if (i_cfg.frame_format == FMT_RAW) begin
            if (!i_state.byte_position[0]) begin
                o_state.partial_sample = {8'h00, i_data_byte};
                step = 1'b1;
            end else begin
                emit = 1'b1;
                val  = {8'h00, i_data_byte, i_state.partial_sample[7:0]};
                last = pos_p1 >= {n_chan, 1'b0};
            end
        end else if (i_state.byte_position < 9'd3) begin
            o_state.header_bytes = word[23:0];
            step = 1'b1;
        end else if (i_state.byte_position == 9'd3) begin
            if (word == want) begin
                o_state.byte_position = HDR_LEN;
                o_state.column_count  = '0;
            end else begin
                o_state.byte_position = '0;
            end
        end else if (i_cfg.frame_format == FMT_HEADED) begin
            if (offs >= F1_BODY) begin
                o_state.byte_position = '0;
                o_state.column_count  = '0;
            end else if (r18 < 5'd2) begin
                step = 1'b1;
            end else if (!r18[0]) begin
                o_state.partial_sample = {8'h00, i_data_byte};
                step = 1'b1;
            end else begin
                emit = 1'b1;
                val  = {{8{i_data_byte[7]}}, i_data_byte, i_state.partial_sample[7:0]};
                last = offs == (F1_BODY - 9'd1);
            end
        end else begin
            if (offs >= F2_BODY) begin
                o_state.byte_position = '0;
                o_state.column_count  = '0;
            end else if (offs < F2_SEMG) begin
                if (r27 < 5'd3) begin
                    step = 1'b1;
                end else begin
                    unique case (s3)
                        2'd0: begin
                            o_state.partial_sample = {8'h00, i_data_byte};
                            step = 1'b1;
                        end
                        2'd1: begin
                            o_state.partial_sample = {i_state.partial_sample[7:0], i_data_byte};
                            step = 1'b1;
                        end
                        default: begin
                            emit = 1'b1;
                            val  = {i_state.partial_sample, i_data_byte};
                        end
                    endcase
                end
            end else if (acc_sel == 2'd0) begin
                o_state.accel_status_byte = i_data_byte;
                step = 1'b1;
            end else begin
                emit  = 1'b1;
                accel = 1'b1;
                val   = {14'd0, hi, i_data_byte};
                last  = offs == (F2_BODY - 9'd1);
            end
        end

        // position and column bookkeeping
        if (step) begin
            o_state.byte_position = i_state.byte_position + 9'd1;
        end
        if (emit) begin
            if (last) begin
                o_state.byte_position = '0;
                o_state.column_count  = '0;
            end else begin
                o_state.byte_position = i_state.byte_position + 9'd1;
                o_state.column_count  = i_state.column_count + 7'd1;
            end
        end
    end

    assign o_res_valid        = emit;
    assign o_res.sample_value = val;
    assign o_res.column_index = i_state.column_count;
    assign o_res.is_accel     = accel;
    assign o_res.row_last     = last;

endmodule

/* rtl/emg_frame_deframer.sv */
// top level of the emg stream deframer: config, framing state and output skid
//
// Input channel: one raw stream byte per request (i_in_valid / o_in_ready).
// Output channel: one decoded value per request (o_out_valid / i_out_ready)
// with its column, an accelerometer flag and a last-of-row flag.
// Config port: i_cfg_we writes register i_cfg_index (0 frame format,
// 1 channels per row) with i_cfg_data; a write to either register restarts
// framing, a write to any other index is ignored.
// A byte that completes a value is registered in the result register, or
// in the one skid entry behind it, so a byte is still taken while one
// value waits. One byte per cycle while o_in_ready is high; the whole
// decode of a byte is one pass of logic from the framing state registers
// into the result register. Bytes that complete no value (header, skipped
// and partial bytes) leave no result. Outside reset o_in_ready drops only
// while both the result register and the skid entry are full.
// Reset (synchronous, active low) holds o_in_ready low, clears framing
// state, empties the output and sets format 0 with 64 channels per row.
module emg_frame_deframer import emgfd_pkg::*; #(
    parameter int MAX_CHANNELS = 128
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [1:0]         i_cfg_index,
    input  logic [7:0]         i_cfg_data,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic [7:0]         i_data_byte,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic signed [23:0] o_sample_value,
    output logic [6:0]         o_column_index,
    output logic               o_is_accel,
    output logic               o_row_last
);

    t_cfg    r_cfg;
    t_state  r_st;
    t_state  n_st;
    t_result r_out;
    t_result r_skid;
    t_result step_res;
    logic    r_out_valid;
    logic    r_skid_valid;
    logic    step_valid;
    logic    in_accept;
    logic    res_valid;
    logic    out_free;
    logic    cfg_hit;

    emgfd_step #(
        .MAX_CHANNELS (MAX_CHANNELS)
    ) u_step (
        .i_cfg       (r_cfg),
        .i_state     (r_st),
        .i_data_byte (i_data_byte),
        .o_state     (n_st),
        .o_res_valid (step_valid),
        .o_res       (step_res)
    );

    assign in_accept = i_in_valid && o_in_ready;
    assign res_valid = in_accept && step_valid;
    assign out_free  = !r_out_valid || i_out_ready;
    assign cfg_hit   = i_cfg_we &&
                       (i_cfg_index == REG_FRAME_FORMAT || i_cfg_index == REG_CHANNELS_PER_ROW);

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.frame_format     <= FRAME_FORMAT_RST;
            r_cfg.channels_per_row <= CHANNELS_PER_ROW_RST;
        end else if (i_cfg_we) begin
            if (i_cfg_index == REG_FRAME_FORMAT) begin
                r_cfg.frame_format <= i_cfg_data[1:0];
            end
            if (i_cfg_index == REG_CHANNELS_PER_ROW) begin
                r_cfg.channels_per_row <= i_cfg_data;
            end
        end
    end

    // framing state, restarted by any register write
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= '0;
        end else if (cfg_hit) begin
            r_st.byte_position <= '0;
            r_st.column_count  <= '0;
        end else if (in_accept) begin
            r_st <= n_st;
        end
    end

    // result register with one skid entry
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (out_free) begin
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid <= res_valid;
            end
        end else if (res_valid) begin
            r_skid_valid <= 1'b1;
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (out_free) begin
            if (r_skid_valid) begin
                r_out <= r_skid;
            end else if (res_valid) begin
                r_out <= step_res;
            end
        end else if (res_valid) begin
            r_skid <= step_res;
        end
    end

    assign o_in_ready     = i_rst_n && !r_skid_valid;
    assign o_out_valid    = r_out_valid;
    assign o_sample_value = r_out.sample_value;
    assign o_column_index = r_out.column_index;
    assign o_is_accel     = r_out.is_accel;
    assign o_row_last     = r_out.row_last;

`ifndef ASSERT_OFF
    // skid entry only fills behind a waiting result
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid entry holds a value while the result register is empty");

    // headed frames never run past their body
    a_headed_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cfg.frame_format == FMT_HEADED) |-> (r_st.byte_position <= HDR_LEN + F1_BODY - 9'd1))
        else $error("byte position beyond the headed frame");

    // legacy frames never run past their body
    a_legacy_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cfg.frame_format[1] |-> (r_st.byte_position <= HDR_LEN + F2_BODY - 9'd1))
        else $error("byte position beyond the legacy frame");

    // accelerometer axes sit in columns 16 to 21
    a_accel_columns: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.is_accel) |->
            (r_out.column_index >= 7'd16 && r_out.column_index <= 7'd21))
        else $error("accelerometer value outside its columns");
`endif

endmodule
